[rtl/tsi_pkg.sv]
package tsi_pkg;

  localparam int unsigned NumInterlocks = 7;
  localparam int unsigned NumFlags      = 6;

  localparam logic [3:0] CMD_PATIENT    = 4'd0;
  localparam logic [3:0] CMD_APPROVAL   = 4'd1;
  localparam logic [3:0] CMD_WATER      = 4'd2;
  localparam logic [3:0] CMD_ULTRASOUND = 4'd6;
  localparam logic [3:0] CMD_PLANNING   = 4'd7;
  localparam logic [3:0] CMD_IDLE       = 4'd8;
  localparam logic [3:0] CMD_START      = 4'd9;
  localparam logic [3:0] CMD_PAUSE      = 4'd10;
  localparam logic [3:0] CMD_RESUME     = 4'd11;
  localparam logic [3:0] CMD_STOP       = 4'd12;

  localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_CODE_PLANNING = 3'd1;
  localparam logic [2:0] MODE_CODE_READY    = 3'd2;
  localparam logic [2:0] MODE_CODE_TREATING = 3'd3;
  localparam logic [2:0] MODE_CODE_PAUSED   = 3'd4;
  localparam logic [2:0] MODE_CODE_ALARM    = 3'd5;

  localparam logic [1:0] LEVEL_GREEN  = 2'd0;
  localparam logic [1:0] LEVEL_YELLOW = 2'd1;
  localparam logic [1:0] LEVEL_RED    = 2'd2;

  localparam logic [1:0] APPROVAL_APPROVED = 2'd2;

  localparam logic [2:0] REFUSE_NONE         = 3'd0;
  localparam logic [2:0] REFUSE_INTERLOCKS   = 3'd1;
  localparam logic [2:0] REFUSE_TREATING     = 3'd2;
  localparam logic [2:0] REFUSE_NOT_TREATING = 3'd3;
  localparam logic [2:0] REFUSE_NOT_PAUSED   = 3'd4;

  // device interlocks: water, power, motion, e-stop, ultrasound
  localparam logic [NumInterlocks-1:0] DEVICE_MASK = 7'h7C;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_PLANNING = 6'b000010,
    MODE_READY    = 6'b000100,
    MODE_TREATING = 6'b001000,
    MODE_PAUSED   = 6'b010000,
    MODE_ALARM    = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [3:0] command;
    logic [1:0] value;
  } tsi_req_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic [1:0]               safety_level;
    logic                     can_start;
    logic [NumInterlocks-1:0] interlock_mask;
    logic                     accepted;
    logic [2:0]               refusal;
    logic                     abort_request;
    logic                     snapshot_changed;
  } tsi_rsp_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    c = MODE_CODE_IDLE;
    case (m)
      MODE_IDLE:     c = MODE_CODE_IDLE;
      MODE_PLANNING: c = MODE_CODE_PLANNING;
      MODE_READY:    c = MODE_CODE_READY;
      MODE_TREATING: c = MODE_CODE_TREATING;
      MODE_PAUSED:   c = MODE_CODE_PAUSED;
      MODE_ALARM:    c = MODE_CODE_ALARM;
      default:       c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

  // interlock bit order: patient, plan, water, power, motion, estop, ultrasound
  function automatic logic [NumInterlocks-1:0] build_mask(
    input logic [NumFlags-1:0] flags,
    input logic [1:0]          approval
  );
    return {~flags[5:1], (approval < APPROVAL_APPROVED), ~flags[0]};
  endfunction

  function automatic logic [1:0] mask_level(input logic [NumInterlocks-1:0] m);
    logic [1:0] l;
    if (m == '0) begin
      l = LEVEL_GREEN;
    end else if ((m & DEVICE_MASK) == '0) begin
      l = LEVEL_YELLOW;
    end else begin
      l = LEVEL_RED;
    end
    return l;
  endfunction

endpackage

[rtl/treatment_safety_interlock.sv]
// Channel | Ports                          | Carries
// --------+--------------------------------+------------------------------
// in      | in_valid, in_ready, in_req     | command, value
// out     | out_valid, out_ready, out_rsp  | mode, level, mask, outcome
//
// One request per cycle while out_ready keeps the result register drained;
// its result appears in the cycle after acceptance, computed by the single
// combinational update between the state registers and the result register.
// Synchronous active-low reset: conditions false, approval draft, mode idle.
// in_ready stays high while the result register is empty or being drained.
module treatment_safety_interlock
  import tsi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tsi_req_t in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output tsi_rsp_t out_rsp
);

  logic [NumFlags-1:0]      flags_r, flags_nxt;
  logic [1:0]               approval_r, approval_nxt;
  mode_t                    mode_r, mode_nxt;
  logic                     out_valid_r;
  tsi_rsp_t                 rsp_r, rsp_nxt;

  logic                     take;
  logic [NumFlags-1:0]      flag_bit;
  logic [2:0]               flag_idx;
  logic                     changed;
  logic [NumInterlocks-1:0] mask_cur, mask_new;
  logic [1:0]               level_new;
  logic [2:0]               refusal;
  logic                     abort_pulse;
  logic                     in_treat;

  assign in_ready  = !out_valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  assign mask_cur = build_mask(flags_r, approval_r);
  assign in_treat = (mode_r == MODE_TREATING) || (mode_r == MODE_PAUSED);
  assign flag_idx = (in_req.command == CMD_PATIENT) ? 3'd0 : 3'(in_req.command - 4'd1);
  assign flag_bit = NumFlags'(1) << flag_idx;

  always_comb begin
    flags_nxt    = flags_r;
    approval_nxt = approval_r;
    mode_nxt     = mode_r;
    changed      = 1'b0;
    refusal      = REFUSE_NONE;
    abort_pulse  = 1'b0;

    case (in_req.command) inside
      CMD_PATIENT, [CMD_WATER:CMD_ULTRASOUND]: begin
        if (((flags_r & flag_bit) != '0) != in_req.value[0]) begin
          flags_nxt = flags_r ^ flag_bit;
          changed   = 1'b1;
        end
      end
      CMD_APPROVAL: begin
        if (approval_r != in_req.value) begin
          approval_nxt = in_req.value;
          changed      = 1'b1;
        end
      end
      CMD_PLANNING: begin
        if (!in_treat) mode_nxt = MODE_PLANNING;
      end
      CMD_IDLE: begin
        if (!in_treat) mode_nxt = MODE_IDLE;
      end
      CMD_START: begin
        if (mask_cur != '0) refusal = REFUSE_INTERLOCKS;
        else if (mode_r == MODE_TREATING) refusal = REFUSE_TREATING;
        else mode_nxt = MODE_TREATING;
      end
      CMD_PAUSE: begin
        if (mode_r != MODE_TREATING) refusal = REFUSE_NOT_TREATING;
        else mode_nxt = MODE_PAUSED;
      end
      CMD_RESUME: begin
        if (mode_r != MODE_PAUSED) refusal = REFUSE_NOT_PAUSED;
        else if (mask_cur != '0) refusal = REFUSE_INTERLOCKS;
        else mode_nxt = MODE_TREATING;
      end
      CMD_STOP: begin
        mode_nxt = MODE_IDLE;
      end
      default: begin
      end
    endcase

    mask_new  = build_mask(flags_nxt, approval_nxt);
    level_new = mask_level(mask_new);

    // rebuild: condition commands never move the mode beforehand
    if (changed) begin
      if (in_treat) begin
        if (level_new == LEVEL_RED) begin
          mode_nxt    = MODE_ALARM;
          abort_pulse = 1'b1;
        end
      end else if (mask_new == '0 && mode_r == MODE_IDLE) begin
        mode_nxt = MODE_READY;
      end else if (mask_new != '0 && mode_r == MODE_READY) begin
        mode_nxt = MODE_IDLE;
      end
    end

    rsp_nxt.mode             = mode_code(mode_nxt);
    rsp_nxt.safety_level     = level_new;
    rsp_nxt.can_start        = (mask_new == '0);
    rsp_nxt.interlock_mask   = mask_new;
    rsp_nxt.accepted         = (refusal == REFUSE_NONE);
    rsp_nxt.refusal          = refusal;
    rsp_nxt.abort_request    = abort_pulse;
    rsp_nxt.snapshot_changed = changed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      approval_r  <= '0;
      mode_r      <= MODE_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        flags_r    <= flags_nxt;
        approval_r <= approval_nxt;
        mode_r     <= mode_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_r <= rsp_nxt;
    end
  end

  a_abort_to_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rsp_r.abort_request |->
      rsp_r.mode == MODE_CODE_ALARM && rsp_r.snapshot_changed)
    else $error("abort without rebuild into alarm");

  a_abort_from_treat: assert property (@(posedge clk) disable iff (!rst_n)
    take && abort_pulse |-> in_treat)
    else $error("abort outside treatment");

  a_refusal_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> rsp_r.accepted == (rsp_r.refusal == REFUSE_NONE))
    else $error("accepted and refusal disagree");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(mode_r) && $stable(flags_r) && $stable(approval_r))
    else $error("state moved without a request");

  a_mask_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> rsp_r.interlock_mask == mask_cur)
    else $error("reported mask differs from state");

endmodule

[verif/tb_treatment_safety_interlock.sv]
module tb_treatment_safety_interlock
  import tsi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] CMD_POWER    = 4'd3;
  localparam logic [3:0] CMD_MOTION   = 4'd4;
  localparam logic [3:0] CMD_ESTOP    = 4'd5;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned PHASE0_ITEMS = 440;
  localparam int unsigned PHASE1_ITEMS = 860;
  localparam int unsigned PHASE2_ITEMS = 1280;

  class tsi_status_tracker;
    logic [NumFlags-1:0]      flags;
    logic [1:0]               approval;
    logic [2:0]               mode;
    logic [NumInterlocks-1:0] ilk;
    logic [1:0]               level;
    tsi_rsp_t                 pending_status[$];
    int unsigned              errors;

    function new();
      flags    = '0;
      approval = '0;
      mode     = MODE_CODE_IDLE;
      ilk      = '1;
      level    = LEVEL_RED;
      errors   = 0;
      void'(rebuild_snapshot());
    endfunction

    function bit treating_or_paused();
      return mode == MODE_CODE_TREATING || mode == MODE_CODE_PAUSED;
    endfunction

    // recompute mask and level, then apply the mode rules; returns abort pulse
    function bit rebuild_snapshot();
      bit abort_now;
      abort_now = 1'b0;
      ilk[0]   = ~flags[0];
      ilk[1]   = (approval < APPROVAL_APPROVED);
      ilk[6:2] = ~flags[5:1];
      if (ilk == '0) begin
        level = LEVEL_GREEN;
      end else if ((ilk & DEVICE_MASK) == '0) begin
        level = LEVEL_YELLOW;
      end else begin
        level = LEVEL_RED;
      end
      if (treating_or_paused()) begin
        if (level == LEVEL_RED) begin
          mode      = MODE_CODE_ALARM;
          abort_now = 1'b1;
        end
      end else if (ilk == '0 && mode == MODE_CODE_IDLE) begin
        mode = MODE_CODE_READY;
      end else if (ilk != '0 && mode == MODE_CODE_READY) begin
        mode = MODE_CODE_IDLE;
      end
      return abort_now;
    endfunction

    function void log_request(tsi_req_t req);
      tsi_rsp_t   rsp;
      int         bit_idx;
      bit         changed;
      logic [2:0] refuse;
      changed = 1'b0;
      refuse  = REFUSE_NONE;
      if (req.command == CMD_APPROVAL) begin
        if (approval != req.value) begin
          approval = req.value;
          changed  = 1'b1;
        end
      end else if (req.command <= CMD_ULTRASOUND) begin
        bit_idx = (req.command == CMD_PATIENT) ? 0 : req.command - 1;
        if (flags[bit_idx] != req.value[0]) begin
          flags[bit_idx] = req.value[0];
          changed        = 1'b1;
        end
      end else begin
        case (req.command)
          CMD_PLANNING: begin
            if (!treating_or_paused()) mode = MODE_CODE_PLANNING;
          end
          CMD_IDLE: begin
            if (!treating_or_paused()) mode = MODE_CODE_IDLE;
          end
          CMD_START: begin
            if (ilk != '0) refuse = REFUSE_INTERLOCKS;
            else if (mode == MODE_CODE_TREATING) refuse = REFUSE_TREATING;
            else mode = MODE_CODE_TREATING;
          end
          CMD_PAUSE: begin
            if (mode != MODE_CODE_TREATING) refuse = REFUSE_NOT_TREATING;
            else mode = MODE_CODE_PAUSED;
          end
          CMD_RESUME: begin
            if (mode != MODE_CODE_PAUSED) refuse = REFUSE_NOT_PAUSED;
            else if (ilk != '0) refuse = REFUSE_INTERLOCKS;
            else mode = MODE_CODE_TREATING;
          end
          CMD_STOP: begin
            mode = MODE_CODE_IDLE;
          end
          default: begin
          end
        endcase
      end
      rsp.abort_request    = changed ? rebuild_snapshot() : 1'b0;
      rsp.mode             = mode;
      rsp.safety_level     = level;
      rsp.can_start        = (ilk == '0);
      rsp.interlock_mask   = ilk;
      rsp.accepted         = (refuse == REFUSE_NONE);
      rsp.refusal          = refuse;
      rsp.snapshot_changed = changed;
      pending_status.insert(pending_status.size(), rsp);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_response(tsi_rsp_t got);
      tsi_rsp_t want;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_status.pop_front();
      compare_field("mode", want.mode, got.mode);
      compare_field("safety_level", want.safety_level, got.safety_level);
      compare_field("can_start", want.can_start, got.can_start);
      compare_field("interlock_mask", want.interlock_mask, got.interlock_mask);
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("refusal", want.refusal, got.refusal);
      compare_field("abort_request", want.abort_request, got.abort_request);
      compare_field("snapshot_changed", want.snapshot_changed, got.snapshot_changed);
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tsi_req_t in_req;
  logic     out_valid;
  logic     out_ready;
  tsi_rsp_t out_rsp;

  tsi_status_tracker tracker = new();

  int unsigned items_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned quiet_cycles = 0;
  bit          hold_req;

  treatment_safety_interlock u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.log_request(in_req);
      if (out_valid && out_ready) tracker.check_response(out_rsp);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic [3:0] cmd, input logic [1:0] val);
    tsi_req_t req;
    req.command = cmd;
    req.value   = val;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_status.size() != 0) @(posedge clk);
  endtask

  function automatic logic [1:0] condition_value(input logic [3:0] cmd, input bit on);
    if (cmd == CMD_APPROVAL) return {on, 1'($urandom)};
    return {1'($urandom), on};
  endfunction

  task automatic send_mode_request();
    case ($urandom_range(9, 0))
      0, 1, 2: send_request(CMD_START, 2'($urandom));
      3, 4:    send_request(CMD_PAUSE, 2'($urandom));
      5, 6:    send_request(CMD_RESUME, 2'($urandom));
      7:       send_request(CMD_PLANNING, 2'($urandom));
      8:       send_request(CMD_IDLE, 2'($urandom));
      default: send_request(CMD_STOP, 2'($urandom));
    endcase
  endtask

  // arm the conditions in random order (each skipped one time in ten), run the mode machine, then disturb it
  task automatic run_session();
    int         perm[NumInterlocks];
    int         j;
    int         tmp;
    logic [3:0] cmd;
    for (int i = 0; i < NumInterlocks; i++) perm[i] = i;
    for (int i = NumInterlocks - 1; i > 0; i--) begin
      j       = $urandom_range(i, 0);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < NumInterlocks; i++) begin
      cmd = CMD_PATIENT + 4'(perm[i]);
      if ($urandom_range(9, 0) != 0) send_request(cmd, condition_value(cmd, 1'b1));
    end
    repeat ($urandom_range(6, 1)) send_mode_request();
    cmd = CMD_PATIENT + 4'($urandom_range(NumInterlocks - 1, 0));
    send_request(cmd, condition_value(cmd, 1'b0));
    repeat ($urandom_range(3, 0)) send_mode_request();
  endtask

  task automatic run_random(input int unsigned target);
    while (items_sent < target) begin
      if ($urandom_range(99, 0) < 65) begin
        run_session();
      end else begin
        send_request(4'($urandom_range(CMD_SPARE_HI, CMD_PATIENT)), 2'($urandom));
      end
    end
  endtask

  task automatic run_directed();
    send_request(CMD_START, 2'b00);
    send_request(CMD_PAUSE, 2'b11);
    send_request(CMD_PATIENT, 2'b00);
    send_request(CMD_PLANNING, 2'b00);
    send_request(CMD_PATIENT, 2'b01);
    send_request(CMD_APPROVAL, 2'b01);
    send_request(CMD_APPROVAL, 2'b11);
    send_request(CMD_APPROVAL, 2'b10);
    send_request(CMD_WATER, 2'b11);
    send_request(CMD_POWER, 2'b01);
    send_request(CMD_MOTION, 2'b01);
    send_request(CMD_ESTOP, 2'b01);
    send_request(CMD_ULTRASOUND, 2'b01);
    send_request(CMD_IDLE, 2'b00);
    send_request(CMD_START, 2'b00);
    send_request(CMD_START, 2'b00);
    send_request(CMD_PAUSE, 2'b00);
    send_request(CMD_PLANNING, 2'b00);
    send_request(CMD_RESUME, 2'b00);
    send_request(CMD_RESUME, 2'b00);
    send_request(CMD_APPROVAL, 2'b00);
    send_request(CMD_ESTOP, 2'b10);
    send_request(CMD_ESTOP, 2'b01);
    send_request(CMD_APPROVAL, 2'b10);
    send_request(CMD_START, 2'b00);
    send_request(CMD_STOP, 2'b00);
    send_request(CMD_SPARE_HI, 2'b11);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    items_sent   = 0;
    hold_req     = 1'b0;
    tx_idle_pct  = 27;
    rx_idle_pct  = 67;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(PHASE0_ITEMS);
    drain_results();

    tx_idle_pct = 67;
    rx_idle_pct = 27;
    hold_req    = 1'b1;
    run_random(PHASE1_ITEMS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(PHASE2_ITEMS);
    drain_results();
    repeat (5) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
